FILE: sv/owvm_pkg.sv
// Shared types, constants and the arctangent table for the omni wheel velocity mixer.
// Has no dependencies.
package owvm_pkg;

   localparam int AtanEntries = 24;
   localparam int AngW = 36;

   localparam logic signed [AngW-1:0] Q30HalfPi = 36'sd1686629713;
   localparam logic signed [AngW-1:0] Q30Pi = 36'sd3373259426;
   localparam logic signed [AngW-1:0] Q30TwoPi = 36'sd6746518852;
   localparam logic signed [AngW-1:0] Q30K = 36'sd652032874;

   localparam logic [2:0] CfgGainOne = 3'd0;
   localparam logic [2:0] CfgGainTwo = 3'd1;
   localparam logic [2:0] CfgGainThree = 3'd2;
   localparam logic [2:0] CfgGainFour = 3'd3;
   localparam logic [2:0] CfgStraight = 3'd4;
   localparam logic [2:0] CfgRot = 3'd5;
   localparam logic [2:0] CfgAux = 3'd6;

   typedef struct packed {
      logic [15:0] gain_one;
      logic [15:0] gain_two;
      logic [15:0] gain_three;
      logic [15:0] gain_four;
      logic [31:0] straight;
      logic [31:0] rot;
      logic [31:0] aux;
   } cfg_type;

   // Command fields carried alongside the CORDIC.
   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] omega;
      logic field;
      logic aux;
   } cmd_type;

   function automatic logic signed [AngW-1:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
         3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
         6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
         9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
         18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
         21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return AngW'(signed'({1'b0, v}));
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > 72'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -72'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Sign-magnitude rounding of a product: half away from zero, then saturate.
   function automatic logic signed [31:0] rnd_sat(input logic neg, input logic [65:0] mag,
                                                  input int sh);
      logic [66:0] p;
      logic signed [71:0] r;
      p = ({1'b0, mag} + (67'd1 << (sh - 1))) >> sh;
      r = 72'(signed'({1'b0, p}));
      return sat32(neg ? -r : r);
   endfunction

endpackage

FILE: sv/owvm_cordic.sv
// Pipelined rotation-mode CORDIC giving cos and sin of heading minus a quarter turn.
// Depends on owvm_pkg.
module owvm_cordic #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  owvm_pkg::cmd_type                 in_cmd,
   input  logic signed [15:0]                in_heading,
   output logic                              out_valid,
   output owvm_pkg::cmd_type                 out_cmd,
   output logic signed [owvm_pkg::AngW-1:0]  out_cos,
   output logic signed [owvm_pkg::AngW-1:0]  out_sin
);

   localparam int N = CORDIC_STAGES;
   localparam int W = owvm_pkg::AngW;

   // Stage 0 registers hold the reduced angle; stage i+1 holds after iteration i.
   logic [N:0]                     vld_ff;
   owvm_pkg::cmd_type              cmd_ff [N+1];
   logic signed [W-1:0]            x_ff [N+1];
   logic signed [W-1:0]            y_ff [N+1];
   logic signed [W-1:0]            z_ff [N+1];
   logic [N:0]                     flip_ff;

   logic signed [W-1:0] ang_in, red_in;
   logic                flip_in;

   // Angle reduction into the right half plane.
   // The most negative headings need a full turn added twice.
   always_comb begin
      ang_in = (W'(in_heading) <<< 18) - owvm_pkg::Q30HalfPi;
      if (ang_in > owvm_pkg::Q30Pi) ang_in = ang_in - owvm_pkg::Q30TwoPi;
      if (ang_in < -owvm_pkg::Q30Pi) ang_in = ang_in + owvm_pkg::Q30TwoPi;
      if (ang_in < -owvm_pkg::Q30Pi) ang_in = ang_in + owvm_pkg::Q30TwoPi;
      flip_in = 1'b0;
      red_in = ang_in;
      if (ang_in > owvm_pkg::Q30HalfPi) begin
         red_in = ang_in - owvm_pkg::Q30Pi;
         flip_in = 1'b1;
      end else if (ang_in < -owvm_pkg::Q30HalfPi) begin
         red_in = ang_in + owvm_pkg::Q30Pi;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[N-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd_ff[0]  <= in_cmd;
         x_ff[0]    <= owvm_pkg::Q30K;
         y_ff[0]    <= '0;
         z_ff[0]    <= red_in;
         flip_ff[0] <= flip_in;
      end
   end

   // One micro-rotation per stage; stages beyond the arctangent table pass their values through.
   for (genvar i = 0; i < N; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (adv) begin
            cmd_ff[i+1]  <= cmd_ff[i];
            flip_ff[i+1] <= flip_ff[i];
            if (i >= owvm_pkg::AtanEntries) begin
               x_ff[i+1] <= x_ff[i];
               y_ff[i+1] <= y_ff[i];
               z_ff[i+1] <= z_ff[i];
            end else if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - owvm_pkg::atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + owvm_pkg::atan_q30(i);
            end
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_cmd   = cmd_ff[N];
   assign out_cos   = flip_ff[N] ? -x_ff[N] : x_ff[N];
   assign out_sin   = flip_ff[N] ? -y_ff[N] : y_ff[N];

endmodule

FILE: sv/owvm_mixer.sv
// Rotation, wheel mixing, gains and auxiliary outputs as a multiplier pipeline.
// Depends on owvm_pkg.
module owvm_mixer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  owvm_pkg::cfg_type                 cfg,
   input  logic                              in_valid,
   input  owvm_pkg::cmd_type                 in_cmd,
   input  logic signed [owvm_pkg::AngW-1:0]  in_cos,
   input  logic signed [owvm_pkg::AngW-1:0]  in_sin,
   output logic                              out_valid,
   output logic [191:0]                      out_data
);

   logic [5:0] vld_ff;

   // Stage A: four rotation products.
   logic signed [67:0] pxc_ff, pys_ff, pyc_ff, pxs_ff;
   owvm_pkg::cmd_type  a_cmd_ff;
   // Stage B: rotated command.
   logic signed [31:0] rx_ff, ry_ff, b_w_ff, b_vy_ff;
   logic               b_aux_ff;
   // Stage C: scale products as sign and magnitude.
   logic [65:0]        m_ff [4];
   logic [3:0]         n_ff;
   logic [65:0]        mr_ff, ma_ff;
   logic               nr_ff, na_ff, c_aux_ff;
   // Stage D: rounded terms.
   logic signed [31:0] s_ff [4];
   logic signed [31:0] rot_ff, aux_ff, auxr_ff;
   logic               d_aux_ff;
   // Stage E: wheel difference times gain.
   logic [65:0]        g_ff [4];
   logic [3:0]         gn_ff;
   logic signed [31:0] e_aux_ff, e_auxr_ff;
   logic               e_aux_en_ff;
   // Stage F: output register.
   logic [191:0]       out_ff;

   logic signed [33:0] comb_in [4];
   logic signed [32:0] diff_in [4];
   logic signed [71:0] rsum_x, rsum_y;
   logic [15:0]        gain_in [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], in_valid};
      end
   end

   // Stage A: products for the frame rotation.
   always_ff @(posedge clock) begin
      if (adv) begin
         pxc_ff   <= 68'(in_cmd.vel_x) * 68'(in_cos);
         pys_ff   <= 68'(in_cmd.vel_y) * 68'(in_sin);
         pyc_ff   <= 68'(in_cmd.vel_y) * 68'(in_cos);
         pxs_ff   <= 68'(in_cmd.vel_x) * 68'(in_sin);
         a_cmd_ff <= in_cmd;
      end
   end

   // Stage B: round half up and saturate, or pass the command through.
   always_comb begin
      rsum_x = 72'(pxc_ff) + 72'(pys_ff) + (72'sd1 <<< 29);
      rsum_y = 72'(pyc_ff) - 72'(pxs_ff) + (72'sd1 <<< 29);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff    <= a_cmd_ff.field ? owvm_pkg::sat32(rsum_x >>> 30) : a_cmd_ff.vel_x;
         ry_ff    <= a_cmd_ff.field ? owvm_pkg::sat32(rsum_y >>> 30) : a_cmd_ff.vel_y;
         b_w_ff   <= a_cmd_ff.omega;
         b_vy_ff  <= a_cmd_ff.vel_y;
         b_aux_ff <= a_cmd_ff.aux;
      end
   end

   // Stage C: wheel combinations and scale products.
   always_comb begin
      comb_in[0] = -34'(rx_ff) - 34'(ry_ff);
      comb_in[1] = 34'(rx_ff) - 34'(ry_ff);
      comb_in[2] = 34'(rx_ff) + 34'(ry_ff);
      comb_in[3] = -34'(rx_ff) + 34'(ry_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            n_ff[k] <= comb_in[k] < 0;
            m_ff[k] <= 66'(comb_in[k] < 0 ? -comb_in[k] : comb_in[k]) * 66'(cfg.straight);
         end
         nr_ff    <= b_w_ff < 0;
         mr_ff    <= 66'(b_w_ff < 0 ? -34'(b_w_ff) : 34'(b_w_ff)) * 66'(cfg.rot);
         na_ff    <= b_vy_ff > 0;
         ma_ff    <= 66'(b_vy_ff < 0 ? -34'(b_vy_ff) : 34'(b_vy_ff)) * 66'(cfg.aux);
         c_aux_ff <= b_aux_ff;
      end
   end

   // Stage D: rounding of the scale products; each auxiliary output saturates on its own.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) s_ff[k] <= owvm_pkg::rnd_sat(n_ff[k], m_ff[k], 16);
         rot_ff   <= owvm_pkg::rnd_sat(nr_ff, mr_ff, 16);
         aux_ff   <= owvm_pkg::rnd_sat(na_ff, ma_ff, 16);
         auxr_ff  <= owvm_pkg::rnd_sat(!na_ff, ma_ff, 16);
         d_aux_ff <= c_aux_ff;
      end
   end

   // Stage E: subtract rotation, multiply by the wheel gain.
   always_comb begin
      gain_in[0] = cfg.gain_one;
      gain_in[1] = cfg.gain_two;
      gain_in[2] = cfg.gain_three;
      gain_in[3] = cfg.gain_four;
      for (int k = 0; k < 4; k++) diff_in[k] = 33'(s_ff[k]) - 33'(rot_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            gn_ff[k] <= diff_in[k] < 0;
            g_ff[k]  <= 66'(diff_in[k] < 0 ? -diff_in[k] : diff_in[k]) * 66'(gain_in[k]);
         end
         e_aux_ff    <= aux_ff;
         e_auxr_ff   <= auxr_ff;
         e_aux_en_ff <= d_aux_ff;
      end
   end

   // Stage F: final rounding and packing.
   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff[31:0]    <= owvm_pkg::rnd_sat(gn_ff[0], g_ff[0], 12);
         out_ff[63:32]   <= owvm_pkg::rnd_sat(gn_ff[1], g_ff[1], 12);
         out_ff[95:64]   <= owvm_pkg::rnd_sat(gn_ff[2], g_ff[2], 12);
         out_ff[127:96]  <= owvm_pkg::rnd_sat(gn_ff[3], g_ff[3], 12);
         out_ff[159:128] <= e_aux_en_ff ? e_aux_ff : 32'sd0;
         out_ff[191:160] <= e_aux_en_ff ? e_auxr_ff : 32'sd0;
      end
   end

   assign out_valid = vld_ff[5];
   assign out_data  = out_ff;

endmodule

FILE: sv/omni_wheel_velocity_mixer_core.sv
// Each input transfer passes through the CORDIC registers and then the mixer stages to its result.
// Throughput: one command per cycle; the CORDIC stages and the multiplier
// pipeline each take a new item every cycle and stall together on rsp_tready.
// Reset (synchronous, active high) empties the pipeline and returns the gains
// to 1.0 in Q4.12 and the scales to 1.0 in Q16.16.
// Depends on owvm_pkg, owvm_cordic and owvm_mixer.
module omni_wheel_velocity_mixer_core #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // vel_x, vel_y, omega, heading
   input  logic [111:0] req_tdata,
   // field_frame_enable, aux_enable
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // wheel_one..four_target, aux_left_target, aux_right_target
   output logic [191:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   owvm_pkg::cfg_type cfg_ff;
   owvm_pkg::cmd_type cmd_in, c_cmd;
   logic              adv, c_valid;
   logic signed [owvm_pkg::AngW-1:0] c_cos, c_sin;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_one   <= 16'd4096;
         cfg_ff.gain_two   <= 16'd4096;
         cfg_ff.gain_three <= 16'd4096;
         cfg_ff.gain_four  <= 16'd4096;
         cfg_ff.straight   <= 32'd65536;
         cfg_ff.rot        <= 32'd65536;
         cfg_ff.aux        <= 32'd65536;
      end else if (csr_we) begin
         case (csr_index)
            owvm_pkg::CfgGainOne:   cfg_ff.gain_one   <= csr_wdata[15:0];
            owvm_pkg::CfgGainTwo:   cfg_ff.gain_two   <= csr_wdata[15:0];
            owvm_pkg::CfgGainThree: cfg_ff.gain_three <= csr_wdata[15:0];
            owvm_pkg::CfgGainFour:  cfg_ff.gain_four  <= csr_wdata[15:0];
            owvm_pkg::CfgStraight:  cfg_ff.straight   <= csr_wdata;
            owvm_pkg::CfgRot:       cfg_ff.rot        <= csr_wdata;
            owvm_pkg::CfgAux:       cfg_ff.aux        <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is free or being drained.
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign cmd_in.vel_x = req_tdata[31:0];
   assign cmd_in.vel_y = req_tdata[63:32];
   assign cmd_in.omega = req_tdata[95:64];
   assign cmd_in.field = req_tuser[0];
   assign cmd_in.aux   = req_tuser[1];

   owvm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid), .in_cmd(cmd_in), .in_heading(req_tdata[111:96]),
      .out_valid(c_valid), .out_cmd(c_cmd), .out_cos(c_cos), .out_sin(c_sin)
   );

   owvm_mixer u_mixer (
      .clock(clock), .reset(reset), .adv(adv), .cfg(cfg_ff),
      .in_valid(c_valid), .in_cmd(c_cmd), .in_cos(c_cos), .in_sin(c_sin),
      .out_valid(rsp_tvalid), .out_data(rsp_tdata)
   );

   // A stalled result must hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   // Input is refused only while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused without stall");

   // A zero left auxiliary output comes with a zero right one, as when aux is off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[159:128] == 32'd0 |-> rsp_tdata[191:160] == 32'd0)
      else $error("aux pair inconsistent");

endmodule
